// File: design/smalu_pkg.sv
package smalu_pkg;

  localparam int WORD_W          = 32;
  localparam int OP_W            = 4;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 5;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 40;
  localparam int STEP_W          = 5;

  // operation codes carried on the input tuser
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OP_W-1:0] OP_POP   = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
  localparam logic [OP_W-1:0] OP_SHL   = 4'd6;
  localparam logic [OP_W-1:0] OP_SHR   = 4'd7;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd8;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FEW     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_RD_R,
    S_RD_L,
    S_EXEC,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    FN_ADD,
    FN_SUB,
    FN_MUL,
    FN_DIV,
    FN_SHL,
    FN_SHR
  } alu_fn_t;

  typedef struct packed {
    logic    start;
    alu_fn_t fn;
  } alu_req_t;

  function automatic alu_fn_t op_to_fn(logic [OP_W-1:0] op);
    alu_fn_t fn;
    unique case (op)
      OP_SUB:  fn = FN_SUB;
      OP_MUL:  fn = FN_MUL;
      OP_DIV:  fn = FN_DIV;
      OP_SHL:  fn = FN_SHL;
      OP_SHR:  fn = FN_SHR;
      default: fn = FN_ADD;
    endcase
    return fn;
  endfunction

endpackage

// File: design/smalu_ram.sv
module smalu_ram #(
  parameter int WIDTH = smalu_pkg::WORD_W,
  parameter int DEPTH = smalu_pkg::STACK_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/smalu_unit.sv
module smalu_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  smalu_pkg::alu_req_t          req,
  input  logic [smalu_pkg::WORD_W-1:0] lhs,
  input  logic [smalu_pkg::WORD_W-1:0] rhs,
  output logic                         done,
  output logic [smalu_pkg::WORD_W-1:0] value
);

  localparam int W = smalu_pkg::WORD_W;

  logic                        busy;
  logic                        fix;
  logic [smalu_pkg::STEP_W-1:0] step;
  smalu_pkg::alu_fn_t          fn_q;
  logic                        neg;
  logic [W-1:0]                acc;
  logic [W-1:0]                a;
  logic [W-1:0]                b;

  logic [W-1:0] simple_res;
  logic [W-1:0] lhs_mag;
  logic [W-1:0] rhs_mag;
  logic [W:0]   rem_shift;
  logic [W:0]   trial;
  logic         iterative;

  assign lhs_mag   = lhs[W-1] ? (~lhs + W'(1)) : lhs;
  assign rhs_mag   = rhs[W-1] ? (~rhs + W'(1)) : rhs;
  assign iterative = (req.fn == smalu_pkg::FN_MUL) || (req.fn == smalu_pkg::FN_DIV);

  // combinational result for the non-iterative ops
  always_comb begin
    case (req.fn)
      smalu_pkg::FN_SUB: simple_res = lhs - rhs;
      smalu_pkg::FN_SHL: simple_res = lhs << rhs[4:0];
      smalu_pkg::FN_SHR: simple_res = W'($signed(lhs) >>> rhs[4:0]);
      default:           simple_res = lhs + rhs;
    endcase
  end

  // restoring divide step: acc holds the partial remainder, a the dividend/quotient
  assign rem_shift = {acc, a[W-1]};
  assign trial     = rem_shift - {1'b0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fix  <= 1'b0;
      if (req.start && !iterative) begin
        done <= 1'b1;
      end else if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end else if (fix) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      fn_q  <= req.fn;
      step  <= '1;
      acc   <= '0;
      value <= simple_res;
      if (req.fn == smalu_pkg::FN_DIV) begin
        a   <= lhs_mag;
        b   <= rhs_mag;
        neg <= lhs[W-1] ^ rhs[W-1];
      end else begin
        a   <= lhs;
        b   <= rhs;
        neg <= 1'b0;
      end
    end else if (busy) begin
      step <= step - smalu_pkg::STEP_W'(1);
      if (fn_q == smalu_pkg::FN_MUL) begin
        // shift-add: accumulate the shifted multiplicand per multiplier bit
        acc <= acc + (b[0] ? a : '0);
        a   <= {a[W-2:0], 1'b0};
        b   <= {1'b0, b[W-1:1]};
      end else begin
        if (!trial[W]) begin
          acc <= trial[W-1:0];
        end else begin
          acc <= rem_shift[W-1:0];
        end
        a <= {a[W-2:0], ~trial[W]};
      end
    end else if (fix) begin
      if (fn_q == smalu_pkg::FN_MUL) begin
        value <= acc;
      end else if (neg) begin
        value <= ~a + W'(1);
      end else begin
        value <= a;
      end
    end
  end

endmodule

// File: design/stack_machine_alu.sv
// RPN stack calculator: a bounded stack of signed 32-bit words with an ALU.
// Send one item per operation: tuser carries the op code (push, pop, add,
// sub, mul, div, shl, shr, print) and tdata the value that push stores.
// Every item returns exactly one result item with a status, the pushed,
// popped or computed word (zero on error), a printed flag and the stack depth
// after the operation. Errors (stack full, too few entries, divide by zero)
// leave the stack untouched. The block works on one item at a time and drops
// s_axis_tready while busy. Per item, push, unknown ops, stack full and too
// few entries pass through decode and finish back to idle; pop and print
// add one stack RAM read; divide by zero stops after the two operand reads;
// add, sub and shifts take two reads of the single-read-port stack RAM plus
// one pass through the ALU; mul and div take the same reads, then spend 32
// bit-serial steps, a sign fix and a done strobe in the shared ALU. The
// finished result waits in an output register, so the next item is accepted
// while the previous result is still pending; if that result is still
// waiting when the next one finishes, the block holds in its finish step
// until the receiver takes it.
module stack_machine_alu #(
  parameter int STACK_DEPTH = smalu_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [smalu_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // value[31:0]
  input  logic [smalu_pkg::OP_W-1:0]         s_axis_tuser,  // op[3:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [smalu_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // status[1:0], result[33:2],
                                                            // depth[38:34], zero[39]
  output logic                               m_axis_tuser   // printed
);

  localparam int W      = smalu_pkg::WORD_W;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int DW     = smalu_pkg::DEPTH_W;

  smalu_pkg::state_t   state;
  smalu_pkg::state_t   state_next;

  // latched item and operands
  logic [smalu_pkg::OP_W-1:0] op_q;
  logic [W-1:0]               val_q;
  logic [W-1:0]               r_q;
  logic [CNT_W-1:0]           cnt;

  // result being built
  logic [smalu_pkg::STATUS_W-1:0] res_status;
  logic [W-1:0]                   res_value;
  logic                           res_printed;

  // output register
  logic                           out_valid;
  logic [smalu_pkg::STATUS_W-1:0] out_status;
  logic [W-1:0]                   out_result;
  logic                           out_printed;
  logic [DW-1:0]                  out_depth;

  // stack RAM and ALU hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [W-1:0]      ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [W-1:0]      ram_rdata;
  smalu_pkg::alu_req_t alu_req;
  logic              alu_done;
  logic [W-1:0]      alu_value;

  logic             in_acc;
  logic             out_free;
  logic             is_push;
  logic             is_pop;
  logic             is_bin;
  logic             full;
  logic             empty;
  logic             few;
  logic             div_zero;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic [CNT_W+DW-1:0] cnt_wide;

  assign s_axis_tready = (state == smalu_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign is_push  = (op_q == smalu_pkg::OP_PUSH);
  assign is_pop   = (op_q == smalu_pkg::OP_POP) || (op_q == smalu_pkg::OP_PRINT);
  assign is_bin   = (op_q >= smalu_pkg::OP_ADD) && (op_q <= smalu_pkg::OP_SHR);
  assign full     = (cnt == CNT_W'(STACK_DEPTH));
  assign empty    = (cnt == '0);
  assign few      = (cnt < CNT_W'(2));
  assign div_zero = (op_q == smalu_pkg::OP_DIV) && (r_q == '0);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign cnt_m2   = cnt - CNT_W'(2);
  // depth is reported modulo 32
  assign cnt_wide = {{DW{1'b0}}, cnt};

  smalu_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH),
    .AW    (ADDR_W)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smalu_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .lhs   (ram_rdata),
    .rhs   (r_q),
    .done  (alu_done),
    .value (alu_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smalu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      smalu_pkg::S_IDLE: begin
        if (in_acc) state_next = smalu_pkg::S_DECODE;
      end
      smalu_pkg::S_DECODE: begin
        if (is_pop && !empty) begin
          state_next = smalu_pkg::S_POP;
        end else if (is_bin && !few) begin
          state_next = smalu_pkg::S_RD_R;
        end else begin
          state_next = smalu_pkg::S_FINISH;
        end
      end
      smalu_pkg::S_POP:  state_next = smalu_pkg::S_FINISH;
      smalu_pkg::S_RD_R: state_next = smalu_pkg::S_RD_L;
      smalu_pkg::S_RD_L: begin
        state_next = div_zero ? smalu_pkg::S_FINISH : smalu_pkg::S_EXEC;
      end
      smalu_pkg::S_EXEC: begin
        if (alu_done) state_next = smalu_pkg::S_FINISH;
      end
      smalu_pkg::S_FINISH: begin
        if (out_free) state_next = smalu_pkg::S_IDLE;
      end
      default: state_next = smalu_pkg::S_IDLE;
    endcase
  end

  // RAM and ALU controls
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = cnt[ADDR_W-1:0];
    ram_wdata     = val_q;
    ram_raddr     = cnt_m1[ADDR_W-1:0];
    alu_req.start = 1'b0;
    alu_req.fn    = smalu_pkg::op_to_fn(op_q);
    unique case (state)
      smalu_pkg::S_DECODE: begin
        // push writes above the top; pops and binaries read the top
        ram_we = is_push && !full;
      end
      smalu_pkg::S_RD_R: begin
        ram_raddr = cnt_m2[ADDR_W-1:0];
      end
      smalu_pkg::S_RD_L: begin
        alu_req.start = !div_zero;
      end
      smalu_pkg::S_EXEC: begin
        // result replaces the left operand
        ram_we    = alu_done;
        ram_waddr = cnt_m2[ADDR_W-1:0];
        ram_wdata = alu_value;
      end
      default: begin
      end
    endcase
  end

  // stack count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == smalu_pkg::S_DECODE && is_push && !full) begin
      cnt <= cnt + CNT_W'(1);
    end else if (state == smalu_pkg::S_POP) begin
      cnt <= cnt_m1;
    end else if (state == smalu_pkg::S_EXEC && alu_done) begin
      cnt <= cnt_m1;
    end
  end

  // item, operands and result fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q  <= s_axis_tuser;
      val_q <= s_axis_tdata;
    end
    if (state == smalu_pkg::S_RD_R) begin
      r_q <= ram_rdata;
    end
    unique case (state)
      smalu_pkg::S_DECODE: begin
        res_status  <= smalu_pkg::ST_OK;
        res_value   <= '0;
        res_printed <= 1'b0;
        if (is_push) begin
          if (full) begin
            res_status <= smalu_pkg::ST_FULL;
          end else begin
            res_value <= val_q;
          end
        end else if ((is_pop && empty) || (is_bin && few)) begin
          res_status <= smalu_pkg::ST_FEW;
        end
      end
      smalu_pkg::S_POP: begin
        res_value   <= ram_rdata;
        res_printed <= (op_q == smalu_pkg::OP_PRINT);
      end
      smalu_pkg::S_RD_L: begin
        if (div_zero) res_status <= smalu_pkg::ST_DIVZERO;
      end
      smalu_pkg::S_EXEC: begin
        if (alu_done) res_value <= alu_value;
      end
      default: begin
      end
    endcase
  end

  // output register: load on finish, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == smalu_pkg::S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == smalu_pkg::S_FINISH && out_free) begin
      out_status  <= res_status;
      out_result  <= res_value;
      out_printed <= res_printed;
      out_depth   <= cnt_wide[DW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_depth, out_result, out_status};
  assign m_axis_tuser  = out_printed;

endmodule

// File: design/smalu_chk.sv
module smalu_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [smalu_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while busy");

  a_print_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == smalu_pkg::ST_OK)
    else $error("printed flag on an error result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != smalu_pkg::ST_OK |-> m_axis_tdata[33:2] == '0)
    else $error("error result carries a nonzero word");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind stack_machine_alu smalu_chk u_smalu_chk (.*);

// File: test/stack_machine_alu_tb.sv
module stack_machine_alu_tb;

  localparam int NUM_ENTRIES = smalu_pkg::STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int TRAIL_CYCLES = 60;

  // op codes that the block must ignore
  localparam logic [smalu_pkg::OP_W-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [smalu_pkg::OP_W-1:0] OP_SPARE_HI = 4'd15;

  localparam logic [smalu_pkg::WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [smalu_pkg::WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [smalu_pkg::WORD_W-1:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [smalu_pkg::STATUS_W-1:0] status;
    logic [smalu_pkg::WORD_W-1:0]   word;
    logic                           printed;
    logic [smalu_pkg::DEPTH_W-1:0]  depth;
  } calc_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_valid = 1'b0;
  logic                            s_ready;
  logic [smalu_pkg::S_TDATA_W-1:0] s_data = '0;
  logic [smalu_pkg::OP_W-1:0]      s_user = smalu_pkg::OP_PUSH;
  logic                            m_valid;
  logic                            m_ready = 1'b0;
  logic [smalu_pkg::M_TDATA_W-1:0] m_data;
  logic                            m_user;

  // stack as the block should hold it
  logic [smalu_pkg::WORD_W-1:0] calc_stack [NUM_ENTRIES];
  int unsigned                  calc_count = 0;

  calc_out_t   expected_q [$];
  int unsigned items_sent = 0;
  int unsigned failures = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic [smalu_pkg::OP_W-1:0] binary_ops [6] = '{smalu_pkg::OP_ADD, smalu_pkg::OP_SUB,
                                                 smalu_pkg::OP_MUL, smalu_pkg::OP_DIV,
                                                 smalu_pkg::OP_SHL, smalu_pkg::OP_SHR};

  stack_machine_alu DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // value[31:0]
    .s_axis_tuser  (s_user),   // op[3:0]
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),   // status[1:0], result[33:2], depth[38:34], zero[39]
    .m_axis_tuser  (m_user)    // printed
  );

  always #10 clk = ~clk;

  // Apply one operation to the predicted stack and return the result item
  // the block owes for it.
  function automatic calc_out_t calc_step(input logic [smalu_pkg::OP_W-1:0] op,
                                          input logic [smalu_pkg::WORD_W-1:0] value);
    calc_out_t                           out;
    logic signed [smalu_pkg::WORD_W-1:0] lhs;
    logic signed [smalu_pkg::WORD_W-1:0] rhs;
    logic [smalu_pkg::WORD_W-1:0]        acc;
    logic                                div_by_zero;
    out = '0;
    acc = '0;
    div_by_zero = 1'b0;
    if (op == smalu_pkg::OP_PUSH) begin
      if (calc_count >= NUM_ENTRIES) begin
        out.status = smalu_pkg::ST_FULL;
      end else begin
        calc_stack[calc_count] = value;
        calc_count++;
        out.word = value;
      end
    end else if (op == smalu_pkg::OP_POP || op == smalu_pkg::OP_PRINT) begin
      if (calc_count == 0) begin
        out.status = smalu_pkg::ST_FEW;
      end else begin
        calc_count--;
        out.word = calc_stack[calc_count];
        out.printed = (op == smalu_pkg::OP_PRINT);
      end
    end else if (op >= smalu_pkg::OP_ADD && op <= smalu_pkg::OP_SHR) begin
      if (calc_count < 2) begin
        out.status = smalu_pkg::ST_FEW;
      end else begin
        // right operand sits on top, left just below it
        rhs = calc_stack[calc_count-1];
        lhs = calc_stack[calc_count-2];
        case (op)
          smalu_pkg::OP_ADD: acc = lhs + rhs;
          smalu_pkg::OP_SUB: acc = lhs - rhs;
          smalu_pkg::OP_MUL: acc = lhs * rhs;
          smalu_pkg::OP_DIV: begin
            if (rhs == 0) div_by_zero = 1'b1;
            else if (lhs == WORD_MIN && rhs == WORD_ALL_ONES) acc = WORD_MIN;
            else acc = lhs / rhs;
          end
          smalu_pkg::OP_SHL: acc = lhs << rhs[4:0];
          default: acc = lhs >>> rhs[4:0];
        endcase
        if (div_by_zero) begin
          out.status = smalu_pkg::ST_DIVZERO;
        end else begin
          calc_count--;
          calc_stack[calc_count-1] = acc;
          out.word = acc;
        end
      end
    end
    out.depth = calc_count[smalu_pkg::DEPTH_W-1:0];
    return out;
  endfunction

  // Hold one item on the input until the block takes it, then log the
  // expected result. The item stays on the bus until the next call changes it.
  task automatic send_item(input logic [smalu_pkg::OP_W-1:0] op,
                           input logic [smalu_pkg::WORD_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= value;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    expected_q.push_back(calc_step(op, value));
    if (op <= smalu_pkg::OP_PRINT) items_sent++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_for_drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Drive ready at random and check each result item against the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    calc_out_t exp_out;
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_valid && m_ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with no expected result: tdata=%h tuser=%b", m_data, m_user);
        failures++;
      end else begin
        exp_out = expected_q.pop_front();
        if (m_data[1:0] !== exp_out.status) begin
          $error("status: expected %0d, got %0d", exp_out.status, m_data[1:0]);
          failures++;
        end
        if (m_data[33:2] !== exp_out.word) begin
          $error("result: expected %h, got %h", exp_out.word, m_data[33:2]);
          failures++;
        end
        if (m_data[38:34] !== exp_out.depth) begin
          $error("depth: expected %0d, got %0d", exp_out.depth, m_data[38:34]);
          failures++;
        end
        if (m_data[39] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_data[39]);
          failures++;
        end
        if (m_user !== exp_out.printed) begin
          $error("printed: expected %b, got %b", exp_out.printed, m_user);
          failures++;
        end
      end
    end
  end

  // Bias toward the values where arithmetic tends to break.
  function automatic logic [smalu_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'd1;
      2: return WORD_ALL_ONES;
      3: return WORD_MAX;
      4: return WORD_MIN;
      5: return $urandom_range(40);
      default: return $urandom();
    endcase
  endfunction

  // Pop and print on an empty stack, then a binary op with one entry.
  task automatic test_empty_stack();
    send_item(smalu_pkg::OP_PRINT, WORD_ALL_ONES);
    send_item(smalu_pkg::OP_POP, WORD_MIN);
    send_item(smalu_pkg::OP_PUSH, WORD_MAX);
    send_item(smalu_pkg::OP_ADD, '0);
    send_item(smalu_pkg::OP_PRINT, '0);
  endtask

  // Wrap-around, the signed divide corners, divide by zero and shift masking.
  task automatic test_alu_corners();
    send_item(smalu_pkg::OP_PUSH, WORD_MAX);
    send_item(smalu_pkg::OP_PUSH, 32'd1);
    send_item(smalu_pkg::OP_ADD, '0);               // wraps to the most negative value
    send_item(smalu_pkg::OP_PUSH, WORD_ALL_ONES);
    send_item(smalu_pkg::OP_DIV, '0);               // most negative / -1 stays put
    send_item(smalu_pkg::OP_PUSH, '0);
    send_item(smalu_pkg::OP_DIV, '0);               // divide by zero keeps both operands
    send_item(smalu_pkg::OP_POP, '0);
    send_item(smalu_pkg::OP_PUSH, 32'd33);
    send_item(smalu_pkg::OP_SHR, '0);               // shift of 33 uses 1, sign fills in
    send_item(smalu_pkg::OP_PUSH, 32'd3);
    send_item(smalu_pkg::OP_SUB, '0);
    send_item(smalu_pkg::OP_PUSH, 32'h0001_0001);
    send_item(smalu_pkg::OP_MUL, '0);
    send_item(smalu_pkg::OP_PUSH, 32'hFFFF_FFF9);   // -7
    send_item(smalu_pkg::OP_PUSH, 32'd2);
    send_item(smalu_pkg::OP_DIV, '0);               // truncates toward zero: -3
    send_item(smalu_pkg::OP_PUSH, 32'd35);
    send_item(smalu_pkg::OP_SHL, '0);
    send_item(smalu_pkg::OP_PRINT, '0);
    send_item(smalu_pkg::OP_PRINT, '0);
  endtask

  task automatic test_unknown_ops();
    send_item(OP_SPARE_LO, WORD_MAX);
    send_item(OP_SPARE_HI, WORD_ALL_ONES);
  endtask

  // One random stretch: fill to full, drain to empty, operand pairs with a
  // binary op, or raw noise including unknown ops.
  task automatic run_random_burst();
    int unsigned kind;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        while (calc_count < NUM_ENTRIES) send_item(smalu_pkg::OP_PUSH, pick_word());
        repeat ($urandom_range(1, 2)) send_item(smalu_pkg::OP_PUSH, pick_word());
      end
      1: begin
        while (calc_count > 0) begin
          send_item($urandom_range(1) ? smalu_pkg::OP_PRINT : smalu_pkg::OP_POP, pick_word());
        end
        send_item($urandom_range(1) ? smalu_pkg::OP_PRINT : smalu_pkg::OP_POP, pick_word());
      end
      9: begin
        repeat ($urandom_range(1, 4)) begin
          send_item(smalu_pkg::OP_W'($urandom_range(15)), $urandom());
        end
      end
      default: begin
        if (calc_count >= NUM_ENTRIES - 1) send_item(smalu_pkg::OP_PRINT, $urandom());
        send_item(smalu_pkg::OP_PUSH, pick_word());
        send_item(smalu_pkg::OP_PUSH, pick_word());
        send_item(binary_ops[$urandom_range(5)], $urandom());
        if ($urandom_range(1)) send_item(smalu_pkg::OP_PRINT, $urandom());
      end
    endcase
  endtask

  // Four idling phases, each running to its share of the random items.
  task automatic test_random_ops();
    int unsigned target;
    int unsigned phase;
    int unsigned send_pct [4] = '{0, 61, 0, 22};
    int unsigned recv_pct [4] = '{0, 0, 61, 22};
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) run_random_burst();
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    // let the block run dry once mid-sequence
    wait_for_drain();
    test_alu_corners();
    test_unknown_ops();
    wait_for_drain();
    test_random_ops();
    wait_for_drain();
    repeat (TRAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(20 * 400_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
